[hw/rtl/ntaf_pkg.sv]
package ntaf_pkg;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_F    = 8'h46;
	localparam logic [7:0] CHAR_X    = 8'h58;

	localparam logic [3:0] NIB_TEN     = 4'd10;
	localparam logic [7:0] ALPHA_SKIP  = 8'd7;
	localparam logic [3:0] DABBLE_MIN  = 4'd5;
	localparam logic [3:0] DABBLE_ADD  = 4'd3;

	typedef logic [7:0] char_t;

	// Serves both decimal digits and upper-case hex digits.
	function automatic char_t nibble_to_ascii(input logic [3:0] nib);
		char_t c;
		c = CHAR_ZERO + {4'h0, nib};
		if (nib >= NIB_TEN) begin
			c = c + ALPHA_SKIP;
		end
		return c;
	endfunction

endpackage

[hw/rtl/number_to_ascii_formatter_core.sv]
// Converts one unsigned number per request into ASCII text, one character per response,
// most significant character first, with last set on the final character. Decimal requests
// pass the value through a shift-and-add-3 converter one bit per cycle; the digit register
// is then shifted out one digit per cycle while the output can take a character, leading
// zeros being dropped in the same slots. Hex requests give '0' and 'X' first and then the
// digits in the same slots, the slots above the digit count being skipped; a hex request
// with a digit count of zero is taken and gives no response. A new request is taken once
// the last character has been placed in the output register, while that character still
// waits to be taken.
module number_to_ascii_formatter_core #(
	parameter int VALUE_WIDTH    = 32,
	parameter int DEC_DIGITS_MAX = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic                   req_type,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [3:0]             digit_count,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic [7:0]             ascii_char,
	output logic                   last
);

	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int HEX_CLAMP  = VALUE_WIDTH / 4;
	localparam int SR_DIGITS  = (HEX_DIGITS > DEC_DIGITS_MAX) ? HEX_DIGITS : DEC_DIGITS_MAX;
	localparam int SR_W       = 4 * SR_DIGITS;
	localparam int DEC_W      = 4 * DEC_DIGITS_MAX;
	localparam int REM_W      = $clog2(SR_DIGITS + 1);
	localparam int CYC_W      = $clog2(VALUE_WIDTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_PRE0 = 3'd2;
	localparam logic [2:0] ST_PREX = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]             state_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [SR_W-1:0]        sr_q;
	logic [CYC_W-1:0]       cyc_q;
	logic [REM_W-1:0]       rem_q;
	logic [REM_W-1:0]       lim_q;
	logic                   dec_q;
	logic                   started_q;
	logic                   ovf_q;
	logic                   rsp_valid_q;
	ntaf_pkg::char_t        char_q;
	logic                   last_q;

	logic [SR_W-1:0]  adj;
	logic [SR_W-1:0]  conv_next;
	logic             carry;
	logic [3:0]       top;
	logic             skip;
	logic             can_load;
	logic             rsp_load;
	logic [REM_W-1:0] hex_lim;

	assign req_ready  = (state_q == ST_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign ascii_char = char_q;
	assign last       = last_q;

	always_comb begin
		adj = sr_q;
		for (int i = 0; i < DEC_DIGITS_MAX; i++) begin
			if (sr_q[4*i +: 4] >= ntaf_pkg::DABBLE_MIN) begin
				adj[4*i +: 4] = sr_q[4*i +: 4] + ntaf_pkg::DABBLE_ADD;
			end
		end
		conv_next = {adj[SR_W-2:0], val_q[VALUE_WIDTH-1]};
		for (int i = DEC_W; i < SR_W; i++) begin
			conv_next[i] = 1'b0;
		end
		carry = adj[DEC_W-1];
	end

	assign top      = sr_q[SR_W-1 -: 4];
	assign skip     = (rem_q > lim_q) ||
	                  (dec_q && !started_q && (top == 4'd0) &&
	                   (rem_q > REM_W'(1)) && !ovf_q);
	assign can_load = !rsp_valid_q || rsp_ready;
	assign rsp_load = can_load && ((state_q == ST_PRE0) || (state_q == ST_PREX) ||
	                               ((state_q == ST_EMIT) && !skip));
	assign hex_lim  = (int'(digit_count) > HEX_CLAMP) ? REM_W'(HEX_CLAMP) : REM_W'(digit_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			cyc_q       <= '0;
			rem_q       <= '0;
			lim_q       <= '0;
			dec_q       <= 1'b0;
			started_q   <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						rem_q     <= REM_W'(SR_DIGITS);
						started_q <= 1'b0;
						ovf_q     <= 1'b0;
						dec_q     <= !req_type;
						if (!req_type) begin
							lim_q   <= REM_W'(DEC_DIGITS_MAX);
							cyc_q   <= CYC_W'(VALUE_WIDTH);
							state_q <= ST_CONV;
						end else if (digit_count != 4'd0) begin
							lim_q   <= hex_lim;
							state_q <= ST_PRE0;
						end
					end
				end
				ST_CONV: begin
					ovf_q <= ovf_q | carry;
					cyc_q <= cyc_q - CYC_W'(1);
					if (cyc_q == CYC_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_PRE0: begin
					if (can_load) begin
						state_q <= ST_PREX;
					end
				end
				ST_PREX: begin
					if (can_load) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (skip) begin
						rem_q <= rem_q - REM_W'(1);
					end else if (can_load) begin
						started_q <= 1'b1;
						rem_q     <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					val_q <= value;
					if (!req_type) begin
						sr_q <= '0;
					end else begin
						sr_q <= SR_W'(value);
					end
				end
			end
			ST_CONV: begin
				sr_q  <= conv_next;
				val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			end
			ST_PRE0: begin
				if (can_load) begin
					char_q <= ntaf_pkg::CHAR_ZERO;
					last_q <= 1'b0;
				end
			end
			ST_PREX: begin
				if (can_load) begin
					char_q <= ntaf_pkg::CHAR_X;
					last_q <= 1'b0;
				end
			end
			ST_EMIT: begin
				if (skip) begin
					sr_q <= {sr_q[SR_W-5:0], 4'b0000};
				end else if (can_load) begin
					sr_q   <= {sr_q[SR_W-5:0], 4'b0000};
					char_q <= ntaf_pkg::nibble_to_ascii(top);
					last_q <= (rem_q == REM_W'(1));
				end
			end
			default: begin
				sr_q <= sr_q;
			end
		endcase
	end

endmodule

[hw/rtl/ntaf_checker.sv]
module ntaf_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   req_type,
	input logic [VALUE_WIDTH-1:0] value,
	input logic [3:0]             digit_count,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [7:0]             ascii_char,
	input logic                   last
);

	// A request that is not taken stays as it is.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req_type) && $stable(value) &&
		                            $stable(digit_count))
		else $error("request changed while waiting");

	// A response that is not taken stays as it is.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(ascii_char) && $stable(last))
		else $error("response changed while stalled");

	// A request that produces text keeps the block busy in the following cycle.
	a_busy_after_text: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (!req_type || digit_count != 4'd0) |=> !req_ready)
		else $error("request taken while a conversion was under way");

	// While a character other than the final one is offered, no new request is taken.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> !req_ready)
		else $error("ready for a new request before the final character");

	// Only digits, upper-case hex letters and the prefix letter are ever produced.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (ascii_char >= ntaf_pkg::CHAR_ZERO && ascii_char <= ntaf_pkg::CHAR_NINE) ||
		              (ascii_char >= ntaf_pkg::CHAR_A && ascii_char <= ntaf_pkg::CHAR_F) ||
		              (ascii_char == ntaf_pkg::CHAR_X))
		else $error("character outside the expected set");

endmodule

bind number_to_ascii_formatter_core ntaf_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_ntaf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.req_type    (req_type),
	.value       (value),
	.digit_count (digit_count),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.ascii_char  (ascii_char),
	.last        (last)
);

[verif/tb_top.sv]
module tb_top;

	localparam int VALUE_BITS   = 32;
	localparam int DEC_MAX      = 10;
	localparam int HEX_MAX      = VALUE_BITS / 4;
	localparam int RANDOM_ITEMS = 430;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_MAX   = 10;

	localparam logic MODE_DEC = 1'b0;
	localparam logic MODE_HEX = 1'b1;

	typedef struct packed {
		ntaf_pkg::char_t ch;
		logic            last;
	} text_char_t;

	class text_scoreboard;
		text_char_t expected_text[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void note_request(input logic mode, input logic [VALUE_BITS-1:0] number,
				input logic [3:0] count);
			logic [VALUE_BITS-1:0] rest;
			logic [3:0] digits[DEC_MAX];
			logic [3:0] nib;
			ntaf_pkg::char_t c;
			int n;
			int width;
			int i;
			if (mode == MODE_DEC) begin
				rest = number;
				n = 0;
				do begin
					digits[n] = 4'(rest % 10);
					rest = rest / 10;
					n++;
				end while (rest != 0 && n < DEC_MAX);
				for (i = n - 1; i >= 0; i--) begin
					c = ntaf_pkg::CHAR_ZERO + {4'h0, digits[i]};
					expected_text.push_back('{c, i == 0});
				end
			end else begin
				width = (count > HEX_MAX) ? HEX_MAX : int'(count);
				if (width == 0) begin
					return;
				end
				expected_text.push_back('{ntaf_pkg::CHAR_ZERO, 1'b0});
				expected_text.push_back('{ntaf_pkg::CHAR_X, 1'b0});
				for (i = width - 1; i >= 0; i--) begin
					nib = number[4*i +: 4];
					c = ntaf_pkg::CHAR_ZERO + {4'h0, nib};
					if (nib > 4'd9) begin
						c = c + ntaf_pkg::ALPHA_SKIP;
					end
					expected_text.push_back('{c, i == 0});
				end
			end
		endfunction

		function void check_char(input ntaf_pkg::char_t ch, input logic is_last);
			text_char_t want;
			if (expected_text.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected character: ascii_char=%02h last=%0d", ch, is_last);
				end
				return;
			end
			want = expected_text.pop_front();
			if (want.ch !== ch || want.last !== is_last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("character mismatch: expected ascii_char=%02h last=%0d, got %02h %0d",
						want.ch, want.last, ch, is_last);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	logic                  req_type = MODE_DEC;
	logic [VALUE_BITS-1:0] value = '0;
	logic [3:0]            digit_count = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	ntaf_pkg::char_t       ascii_char;
	logic                  last;

	text_scoreboard sb = new();
	logic no_idle = 1'b0;
	int cycle_count = 0;

	number_to_ascii_formatter_core #(
		.VALUE_WIDTH(VALUE_BITS),
		.DEC_DIGITS_MAX(DEC_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.value(value),
		.digit_count(digit_count),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.ascii_char(ascii_char),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_request(input logic mode, input logic [VALUE_BITS-1:0] number,
			input logic [3:0] count);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= mode;
		value       <= number;
		digit_count <= count;
		do begin
			@(posedge clk);
		end while (!req_ready);
		sb.note_request(mode, number, count);
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_number();
		logic [VALUE_BITS-1:0] p;
		int k;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 99);
			2: begin
				p = 1;
				for (k = $urandom_range(0, 9); k > 0; k--) begin
					p = p * 10;
				end
				return p - $urandom_range(0, 1);
			end
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	initial begin
		int hold;
		hold = 0;
		wait (arst_n);
		@(posedge clk);
		rsp_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				sb.check_char(ascii_char, last);
				hold = no_idle ? 0 : $urandom_range(0, 6);
				if (hold > 0) begin
					rsp_ready <= 1'b0;
				end
			end else if (hold > 0) begin
				hold--;
				if (hold == 0) begin
					rsp_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		int k;
		int waited;
		int unsigned errors;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_DEC, 32'd0, 4'd0);
		send_request(MODE_DEC, 32'd7, 4'd15);
		send_request(MODE_DEC, 32'd9, 4'd3);
		send_request(MODE_DEC, 32'd10, 4'd0);
		send_request(MODE_DEC, 32'd999999999, 4'd8);
		send_request(MODE_DEC, 32'd1000000000, 4'd1);
		send_request(MODE_DEC, 32'hFFFFFFFF, 4'd0);
		send_request(MODE_DEC, 32'h80000000, 4'd9);
		send_request(MODE_HEX, 32'h12345678, 4'd0);
		send_request(MODE_HEX, 32'h12345678, 4'd1);
		send_request(MODE_HEX, 32'h00000000, 4'd8);
		send_request(MODE_HEX, 32'hFFFFFFFF, 4'd8);
		send_request(MODE_HEX, 32'hDEADBEEF, 4'd9);
		send_request(MODE_HEX, 32'hABCDEF09, 4'd15);
		send_request(MODE_HEX, 32'h89ABCDEF, 4'd4);
		send_request(MODE_HEX, 32'hFFFFFFFF, 4'd0);
		send_request(MODE_HEX, 32'h0000000A, 4'd2);
		send_request(MODE_DEC, 32'd4294967294, 4'd15);
		send_request(MODE_DEC, 32'd100, 4'd0);
		send_request(MODE_HEX, 32'h76543210, 4'd7);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			no_idle = ((k / 40) % 4) == 3;
			send_request($urandom_range(0, 1), pick_number(), $urandom_range(0, 15));
		end
		no_idle = 1'b0;
		req_valid <= 1'b0;

		waited = 0;
		while (sb.expected_text.size() != 0 && waited < CYCLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		errors = sb.mismatches;
		if (sb.expected_text.size() != 0) begin
			$display("%0d expected characters never arrived", sb.expected_text.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

[sim.f]
hw/rtl/ntaf_pkg.sv
hw/rtl/number_to_ascii_formatter_core.sv
hw/rtl/ntaf_checker.sv
verif/tb_top.sv
